>>> rtl/stp_pkg.sv
// Shared constants, codes and control types of the servo trapezoid profile block.
`default_nettype none

package stp_pkg;

   // field and register widths
   localparam int PULSE_BITS_DEF = 12;
   localparam int OP_W           = 2;
   localparam int PERMILLE_W     = 10;
   localparam int STEP_W         = 10;
   localparam int BASE_W         = 12;
   localparam int CSR_DATA_W     = 12;
   localparam int CSR_INDEX_W    = 3;

   // shared multiplier and divider geometry
   localparam int MUL_A_W        = 10;
   localparam int MUL_B_W        = 11;
   localparam int PROD_W         = MUL_A_W + MUL_B_W;
   localparam int DIV_STEPS      = STEP_W;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS + 1);

   // operation codes of an input beat
   localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
   localparam logic [OP_W-1:0] OP_GOTO    = 2'd1;
   localparam logic [OP_W-1:0] OP_DISABLE = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_SPEED = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ACCEL     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_PM    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_PM    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE      = 3'd4;

   // register reset values
   localparam logic [STEP_W-1:0]     RST_MAX_SPEED = 10'd150;
   localparam logic [STEP_W-1:0]     RST_ACCEL     = 10'd30;
   localparam logic [PERMILLE_W-1:0] RST_MIN_PM    = 10'd0;
   localparam logic [PERMILLE_W-1:0] RST_MAX_PM    = 10'd1000;
   localparam logic [BASE_W-1:0]     RST_BASE      = 12'd1000;

   // datapath operations issued by the controller
   typedef enum logic [2:0] {
      DP_IDLE,
      DP_TICK,
      DP_GOTO,
      DP_DISABLE,
      DP_DIV_STEP,
      DP_MUL_AN,
      DP_MUL_N1,
      DP_PLAN
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      capture;
      logic      load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic enabled;
      logic accel_zero;
   } dp_status_type;

endpackage

`default_nettype wire

>>> rtl/stp_if.sv
// Request and response channel interfaces of the servo trapezoid profile block.
`default_nettype none

interface stp_req_if;
   import stp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       op;
   logic [PERMILLE_W-1:0] target_permille;

   modport source (output valid, output op, output target_permille, input ready);
   modport sink   (input valid, input op, input target_permille, output ready);
endinterface

interface stp_rsp_if #(
   parameter int PULSE_BITS = stp_pkg::PULSE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [PULSE_BITS-1:0] pulse_us;
   logic                  output_enabled;
   logic                  at_target;

   modport source (output valid, output pulse_us, output output_enabled, output at_target,
                   input ready);
   modport sink   (input valid, input pulse_us, input output_enabled, input at_target,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/stp_control.sv
// Sequencing state machine of the servo trapezoid profile block.
`default_nettype none

module stp_control (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [stp_pkg::OP_W-1:0]    req_op,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire stp_pkg::dp_status_type      status,
   output stp_pkg::dp_cmd_type              cmd
);
   import stp_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TICK,
      S_GOTO,
      S_DISABLE,
      S_DIV,
      S_MUL_AN,
      S_MUL_N1,
      S_PLAN,
      S_DONE
   } state_type;

   state_type              state_ff;
   logic [DIV_CNT_W-1:0]   count_ff;
   logic                   rsp_valid_ff;
   logic                   accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // issue the datapath operation of the current state
   always_comb begin
      cmd.op       = DP_IDLE;
      cmd.capture  = accept;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         S_IDLE:    cmd.op = DP_IDLE;
         S_TICK:    cmd.op = DP_TICK;
         S_GOTO:    cmd.op = DP_GOTO;
         S_DISABLE: cmd.op = DP_DISABLE;
         S_DIV:     cmd.op = DP_DIV_STEP;
         S_MUL_AN:  cmd.op = DP_MUL_AN;
         S_MUL_N1:  cmd.op = DP_MUL_N1;
         S_PLAN:    cmd.op = DP_PLAN;
         S_DONE:    cmd.load_out = !rsp_valid_ff || rsp_ready;
         default:   cmd.op = DP_IDLE;
      endcase
   end

   // advance the sequence and hold the response beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (req_op)
                     OP_TICK:    state_ff <= S_TICK;
                     OP_GOTO:    state_ff <= S_GOTO;
                     OP_DISABLE: state_ff <= S_DISABLE;
                     default:    state_ff <= S_DONE;
                  endcase
               end
            end
            S_TICK:    state_ff <= S_DONE;
            S_DISABLE: state_ff <= S_DONE;
            S_GOTO: begin
               count_ff <= '0;
               if (!status.enabled) begin
                  state_ff <= S_DONE;
               end else if (status.accel_zero) begin
                  state_ff <= S_PLAN;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= S_MUL_AN;
               end else begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            S_MUL_AN: state_ff <= S_MUL_N1;
            S_MUL_N1: state_ff <= S_PLAN;
            S_PLAN:   state_ff <= S_DONE;
            S_DONE: begin
               if (cmd.load_out) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/stp_datapath.sv
// Registers, ramp step logic, divider and multiplier of the servo trapezoid profile block.
`default_nettype none

module stp_datapath #(
   parameter int PULSE_BITS = stp_pkg::PULSE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [stp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [stp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic [stp_pkg::PERMILLE_W-1:0]    req_target_permille,
   input  wire stp_pkg::dp_cmd_type               cmd,
   output stp_pkg::dp_status_type                 status,
   output logic [PULSE_BITS-1:0]                  pulse_us,
   output logic                                   output_enabled,
   output logic                                   at_target
);
   import stp_pkg::*;

   localparam int T_W = (PULSE_BITS + 1 > BASE_W + 1) ? PULSE_BITS + 1 : BASE_W + 1;
   localparam logic [PULSE_BITS-1:0] PULSE_MAX = '1;

   // configuration
   logic [STEP_W-1:0]     max_speed_ff;
   logic [STEP_W-1:0]     accel_ff;
   logic [PERMILLE_W-1:0] min_pm_ff;
   logic [PERMILLE_W-1:0] max_pm_ff;
   logic [BASE_W-1:0]     base_ff;

   // profile state
   logic [PULSE_BITS-1:0] target_ff;
   logic [PULSE_BITS-1:0] command_ff;
   logic [STEP_W-1:0]     speed_ff;
   logic                  moving_down_ff;
   logic [PULSE_BITS-1:0] decel_ff;
   logic                  enabled_ff;

   // working registers
   logic [PERMILLE_W-1:0] permille_ff;
   logic [STEP_W-1:0]     rem_ff;
   logic [STEP_W-1:0]     quo_ff;
   logic [PROD_W-1:0]     prod_ff;

   // response registers
   logic [PULSE_BITS-1:0] pulse_ff;
   logic                  out_en_ff;
   logic                  at_target_ff;

   logic [PULSE_BITS-1:0] delta;
   logic [PERMILLE_W-1:0] pm_clamped;
   logic [T_W-1:0]        target_sum;
   logic [PULSE_BITS-1:0] target_in;
   logic [STEP_W:0]       div_shifted;
   logic [STEP_W:0]       div_diff;
   logic                  div_ge;
   logic [STEP_W-1:0]     rem_in;
   logic [STEP_W-1:0]     n_eff;
   logic [MUL_B_W-1:0]    n_plus;
   logic [MUL_A_W-1:0]    mul_a;
   logic [MUL_B_W-1:0]    mul_b;
   logic [PROD_W-1:0]     mul_out;
   logic [PROD_W-1:0]     delta_ext;
   logic [PROD_W-1:0]     dd_sel;
   logic [PULSE_BITS-1:0] decel_in;
   logic [PULSE_BITS-1:0] step;
   logic [PULSE_BITS-1:0] half_delta;
   logic [PULSE_BITS-1:0] vmax_ext;
   logic [PULSE_BITS-1:0] acc_ext;

   assign status.enabled    = enabled_ff;
   assign status.accel_zero = (accel_ff == '0);
   assign pulse_us          = pulse_ff;
   assign output_enabled    = out_en_ff;
   assign at_target         = at_target_ff;

   assign delta = (target_ff >= command_ff) ? target_ff - command_ff : command_ff - target_ff;

   // clamp the requested position and convert it to microseconds
   always_comb begin
      if (permille_ff < min_pm_ff) begin
         pm_clamped = min_pm_ff;
      end else if (permille_ff > max_pm_ff) begin
         pm_clamped = max_pm_ff;
      end else begin
         pm_clamped = permille_ff;
      end
      target_sum = T_W'(base_ff) + T_W'(pm_clamped);
      if (target_sum > T_W'(PULSE_MAX)) begin
         target_in = PULSE_MAX;
      end else begin
         target_in = target_sum[PULSE_BITS-1:0];
      end
   end

   // one restoring step of the speed over acceleration division
   assign div_shifted = {rem_ff, quo_ff[STEP_W-1]};
   assign div_diff    = div_shifted - {1'b0, accel_ff};
   assign div_ge      = (div_shifted >= {1'b0, accel_ff});
   assign rem_in      = div_ge ? div_diff[STEP_W-1:0] : div_shifted[STEP_W-1:0];

   // shared multiplier: acc*n, then that product times n+1
   assign n_eff  = (quo_ff == '0) ? STEP_W'(1) : quo_ff;
   assign n_plus = {1'b0, n_eff} + MUL_B_W'(1);

   always_comb begin
      if (cmd.op == DP_MUL_N1) begin
         mul_a = prod_ff[MUL_A_W-1:0];
         mul_b = n_plus;
      end else begin
         mul_a = accel_ff;
         mul_b = {1'b0, n_eff};
      end
      mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // pick the deceleration distance, halved for a triangle move
   always_comb begin
      delta_ext = PROD_W'(delta);
      dd_sel    = PROD_W'(prod_ff[PROD_W-1:1]);
      if (delta_ext < {prod_ff[PROD_W-1:1], 1'b0}) begin
         dd_sel = delta_ext >> 1;
         if (dd_sel == '0) begin
            dd_sel = PROD_W'(1);
         end
      end
      if (accel_ff == '0) begin
         decel_in = '0;
      end else if (dd_sel > PROD_W'(PULSE_MAX)) begin
         decel_in = PULSE_MAX;
      end else begin
         decel_in = dd_sel[PULSE_BITS-1:0];
      end
   end

   // work out the step of one tick: accelerate, cruise or decelerate
   always_comb begin
      vmax_ext   = PULSE_BITS'(max_speed_ff);
      acc_ext    = PULSE_BITS'(accel_ff);
      half_delta = delta >> 1;
      step       = PULSE_BITS'(speed_ff);
      if (accel_ff == '0) begin
         step = vmax_ext;
         if (delta < step) begin
            step = delta;
         end
      end else if (delta <= decel_ff) begin
         if (acc_ext < step) begin
            step = step - acc_ext;
         end else begin
            step = acc_ext;
         end
      end else if (step < vmax_ext) begin
         if (half_delta < acc_ext) begin
            step = half_delta;
         end else begin
            step = step + acc_ext;
         end
         if (vmax_ext < step) begin
            step = vmax_ext;
         end
      end
      if (delta < step) begin
         step = delta;
      end
      if (step == '0) begin
         step = PULSE_BITS'(1);
      end
   end

   // hold configuration and profile state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff   <= RST_MAX_SPEED;
         accel_ff       <= RST_ACCEL;
         min_pm_ff      <= RST_MIN_PM;
         max_pm_ff      <= RST_MAX_PM;
         base_ff        <= RST_BASE;
         target_ff      <= PULSE_BITS'(RST_BASE);
         command_ff     <= PULSE_BITS'(RST_BASE);
         speed_ff       <= '0;
         moving_down_ff <= 1'b0;
         decel_ff       <= '0;
         enabled_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_MAX_SPEED: begin
                  max_speed_ff <= csr_wdata[STEP_W-1:0];
                  command_ff   <= target_ff;
                  speed_ff     <= '0;
               end
               REG_ACCEL: begin
                  accel_ff   <= csr_wdata[STEP_W-1:0];
                  command_ff <= target_ff;
                  speed_ff   <= '0;
               end
               REG_MIN_PM: min_pm_ff <= csr_wdata[PERMILLE_W-1:0];
               REG_MAX_PM: max_pm_ff <= csr_wdata[PERMILLE_W-1:0];
               REG_BASE:   base_ff   <= csr_wdata[BASE_W-1:0];
               default: begin
               end
            endcase
         end

         case (cmd.op)
            DP_TICK: begin
               if (enabled_ff && (command_ff != target_ff)) begin
                  speed_ff <= step[STEP_W-1:0];
                  if (moving_down_ff) begin
                     command_ff <= command_ff - step;
                  end else begin
                     command_ff <= command_ff + step;
                  end
               end
            end
            DP_GOTO: begin
               target_ff <= target_in;
               if (!enabled_ff) begin
                  enabled_ff <= 1'b1;
                  command_ff <= target_in;
               end
            end
            DP_DISABLE: enabled_ff <= 1'b0;
            DP_PLAN: begin
               decel_ff       <= decel_in;
               moving_down_ff <= (command_ff > target_ff);
            end
            default: begin
            end
         endcase
      end
   end

   // capture the beat, run the divider and multiplier, load the response
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         permille_ff <= req_target_permille;
      end
      case (cmd.op)
         DP_GOTO: begin
            rem_ff <= '0;
            quo_ff <= max_speed_ff;
         end
         DP_DIV_STEP: begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[STEP_W-2:0], div_ge};
         end
         DP_MUL_AN, DP_MUL_N1: prod_ff <= mul_out;
         default: begin
         end
      endcase
      if (cmd.load_out) begin
         pulse_ff     <= command_ff;
         out_en_ff    <= enabled_ff;
         at_target_ff <= (command_ff == target_ff);
      end
   end

endmodule

`default_nettype wire

>>> rtl/servo_trapezoid_profile.sv
// Top level of the servo trapezoid profile block: controller, datapath and channel wiring.
// Tick, disable and go-to beats run their own state before the response, an unused code
// none; a running go-to then divides speed by acceleration, forms acc*n and that times
// n+1, and plans, or only plans with ramping off. One beat is in flight at a time; the
// next is taken while a response still waits. Synchronous active-high reset restores
// register defaults, parks command and target at the base pulse width, clears the enable.
`default_nettype none

module servo_trapezoid_profile #(
   parameter int PULSE_BITS = stp_pkg::PULSE_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   stp_req_if.sink                              req_ch,
   stp_rsp_if.source                            rsp_ch,
   input  wire logic                            csr_we,
   input  wire logic [stp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [stp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import stp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequence each beat
   stp_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_op    (req_ch.op),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hold state and compute the profile
   stp_datapath #(
      .PULSE_BITS (PULSE_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_target_permille (req_ch.target_permille),
      .cmd                 (cmd),
      .status              (status),
      .pulse_us            (rsp_ch.pulse_us),
      .output_enabled      (rsp_ch.output_enabled),
      .at_target           (rsp_ch.at_target)
   );

`ifndef SYNTHESIS
   // an accepted beat keeps the block busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken again straight after acceptance");

   // a response is loaded only into a free or draining output stage
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("response overwritten before it was taken");

   // a loaded response is offered in the next cycle
   a_valid_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_ch.valid)
      else $error("loaded response not offered");

   // the datapath only works while a beat is in flight
   a_idle_no_work: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> (cmd.op == DP_IDLE))
      else $error("datapath operation issued while idle");
`endif

endmodule

`default_nettype wire
